// ----- rtl/ictf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ictf_pkg;

  // datapath width of the cordic x/y lanes: 17-bit operand, 2^14 scale, gain growth, sign
  localparam int XW = 34;

  // configuration register indexes
  localparam logic [3:0] CFG_GYRO_GAIN      = 4'd0;
  localparam logic [3:0] CFG_BLEND_WEIGHT   = 4'd1;
  localparam logic [3:0] CFG_MAGNITUDE_LOW  = 4'd2;
  localparam logic [3:0] CFG_MAGNITUDE_HIGH = 4'd3;

  // which angle an item in the cordic chain belongs to
  localparam logic TAG_PITCH = 1'b0;
  localparam logic TAG_ROLL  = 1'b1;

  typedef struct packed {
    logic vld;
    logic tag;
  } ictf_ctl_t;

  // atan(2^-i) in degrees, 24 fraction bits; steps past 23 reuse the last entry
  function automatic longint atan_q24(input int i);
    unique case (i)
      0:       return 64'sd754974720;
      1:       return 64'sd445687602;
      2:       return 64'sd235489088;
      3:       return 64'sd119537938;
      4:       return 64'sd60000934;
      5:       return 64'sd30029717;
      6:       return 64'sd15018523;
      7:       return 64'sd7509720;
      8:       return 64'sd3754917;
      9:       return 64'sd1877466;
      10:      return 64'sd938734;
      11:      return 64'sd469367;
      12:      return 64'sd234684;
      13:      return 64'sd117342;
      14:      return 64'sd58671;
      15:      return 64'sd29335;
      16:      return 64'sd14668;
      17:      return 64'sd7334;
      18:      return 64'sd3667;
      19:      return 64'sd1833;
      20:      return 64'sd917;
      21:      return 64'sd458;
      22:      return 64'sd229;
      default: return 64'sd115;
    endcase
  endfunction

  // table entry rounded half up to the angle fraction width
  function automatic longint atan_entry(input int i, input int frac);
    longint t;
    int     sh;
    t  = atan_q24(i);
    sh = 24 - frac;
    if (sh == 0) return t;
    return (t + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/ictf_cordic_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ictf_cordic_cell import ictf_pkg::*; #(
  parameter int STEP            = 0,
  parameter int ANGLE_FRAC_BITS = 16,
  parameter int ZW              = 26
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire ictf_ctl_t             ctl_i,
  input  wire logic signed [XW-1:0]  x_i,
  input  wire logic signed [XW-1:0]  y_i,
  input  wire logic signed [ZW-1:0]  z_i,
  output ictf_ctl_t                  ctl_o,
  output logic signed [XW-1:0]       x_o,
  output logic signed [XW-1:0]       y_o,
  output logic signed [ZW-1:0]       z_o
);

  localparam logic signed [ZW-1:0] TAB = ZW'(atan_entry(STEP, ANGLE_FRAC_BITS));

  ictf_ctl_t                ctl_r;
  logic signed [XW-1:0]     x_r, y_r, x_nxt, y_nxt;
  logic signed [ZW-1:0]     z_r, z_nxt;
  logic signed [XW-1:0]     dx, dy;
  logic                     rot_pos;

  assign dx      = y_i >>> STEP;
  assign dy      = x_i >>> STEP;
  assign rot_pos = !y_i[XW-1] && (y_i != '0);

  always_comb begin
    if (rot_pos) begin
      x_nxt = x_i + dx;
      y_nxt = y_i - dy;
      z_nxt = z_i + TAB;
    end else begin
      x_nxt = x_i - dx;
      y_nxt = y_i + dy;
      z_nxt = z_i - TAB;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  assign ctl_o = ctl_r;
  assign x_o   = x_r;
  assign y_o   = y_r;
  assign z_o   = z_r;

endmodule

`default_nettype wire

// ----- rtl/ictf_cordic_chain.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ictf_cordic_chain import ictf_pkg::*; #(
  parameter int CORDIC_STEPS    = 16,
  parameter int ANGLE_FRAC_BITS = 16,
  parameter int ZW              = 26
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire ictf_ctl_t             ctl_i,
  input  wire logic signed [15:0]    y_i,
  input  wire logic signed [15:0]    x_i,
  output ictf_ctl_t                  ctl_o,
  output logic signed [ZW-1:0]       z_o
);

  localparam logic signed [ZW-1:0] Z180 = ZW'(longint'(180) << ANGLE_FRAC_BITS);

  // entry stage: fold left half plane, scale by 2^14
  ictf_ctl_t             ctl_s [0:CORDIC_STEPS];
  logic signed [XW-1:0]  x_s   [0:CORDIC_STEPS];
  logic signed [XW-1:0]  y_s   [0:CORDIC_STEPS];
  logic signed [ZW-1:0]  z_s   [0:CORDIC_STEPS];

  ictf_ctl_t             ctl0_r;
  logic signed [XW-1:0]  x0_r, y0_r, x0_nxt, y0_nxt;
  logic signed [ZW-1:0]  z0_r, z0_nxt;
  logic signed [16:0]    xe, ye;

  always_comb begin
    if (x_i[15]) begin
      xe     = -{x_i[15], x_i};
      ye     = -{y_i[15], y_i};
      z0_nxt = y_i[15] ? -Z180 : Z180;
    end else begin
      xe     = {x_i[15], x_i};
      ye     = {y_i[15], y_i};
      z0_nxt = '0;
    end
    x0_nxt = {{(XW-31){xe[16]}}, xe, 14'b0};
    y0_nxt = {{(XW-31){ye[16]}}, ye, 14'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl0_r <= '0;
    end else begin
      ctl0_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    x0_r <= x0_nxt;
    y0_r <= y0_nxt;
    z0_r <= z0_nxt;
  end

  assign ctl_s[0] = ctl0_r;
  assign x_s[0]   = x0_r;
  assign y_s[0]   = y0_r;
  assign z_s[0]   = z0_r;

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
    ictf_cordic_cell #(
      .STEP            (g),
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
      .ZW              (ZW)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl_i (ctl_s[g]),
      .x_i   (x_s[g]),
      .y_i   (y_s[g]),
      .z_i   (z_s[g]),
      .ctl_o (ctl_s[g+1]),
      .x_o   (x_s[g+1]),
      .y_o   (y_s[g+1]),
      .z_o   (z_s[g+1])
    );
  end

  assign ctl_o = ctl_s[CORDIC_STEPS];
  assign z_o   = z_s[CORDIC_STEPS];

endmodule

`default_nettype wire

// ----- rtl/imu_complementary_tilt_filter_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// each item takes the gyro step, then pitch and roll atan2 through the cordic chain,
//   then with accel correction the blend multiply and sum (skipped without it)
// a new item is accepted only in the idle state, after the previous one is done; the
//   time per item is set by the entry stage plus one cell per step of the cordic
//   chain that both atan2 pass through
// a held output item delays the next acceptance only while the output register is full
// reset (rst_n low, synchronous): angles cleared, registers to defaults, no item pending

module imu_complementary_tilt_filter_core import ictf_pkg::*; #(
  parameter int CORDIC_STEPS    = 16,
  parameter int ANGLE_FRAC_BITS = 16
) (
  input  wire         clk,
  input  wire         rst_n,
  // input items
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [79:0] in_tdata,   // gyro_rate_x, gyro_rate_y, accel_x, accel_y, accel_z
  // result items
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [63:0] out_tdata,  // pitch_out, roll_out
  output logic [0:0]  out_tuser,  // accel_used
  // register writes
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [3:0]  cfg_index,
  input  wire  [16:0] cfg_data
);

  // accel angle width: up to about 280 degrees of swing plus sign
  localparam int ZW = ANGLE_FRAC_BITS + 10;
  // blend products and their sum
  localparam int BW = (ZW + 18 > 49) ? ZW + 18 : 49;
  localparam logic signed [BW-1:0] HALF = BW'(32768);

  // sequencer codes
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_ADD  = 3'd2;
  localparam logic [2:0] S_WAIT = 3'd3;
  localparam logic [2:0] S_BMUL = 3'd4;
  localparam logic [2:0] S_BSUM = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0] state_r, state_nxt;

  // configuration registers
  logic [15:0] gain_r, weight_r;
  logic [16:0] mag_lo_r, mag_hi_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r   <= 16'd10;
      weight_r <= 16'd64225;
      mag_lo_r <= 17'd8192;
      mag_hi_r <= 17'd32768;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_GYRO_GAIN:      gain_r   <= cfg_data[15:0];
        CFG_BLEND_WEIGHT:   weight_r <= cfg_data[15:0];
        CFG_MAGNITUDE_LOW:  mag_lo_r <= cfg_data;
        CFG_MAGNITUDE_HIGH: mag_hi_r <= cfg_data;
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  // sample registers
  logic signed [15:0] gx_r, gy_r, ax_r, ay_r, az_r;
  logic               in_acc;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      gx_r <= in_tdata[15:0];
      gy_r <= in_tdata[31:16];
      ax_r <= in_tdata[47:32];
      ay_r <= in_tdata[63:48];
      az_r <= in_tdata[79:64];
    end
  end

  // gyro products, magnitude window and atan2 zero cases, all taken in S_MUL
  logic signed [32:0] gp_mul, gr_mul;
  logic signed [32:0] gp_mul_r, gr_mul_r;
  logic        [16:0] abs_x, abs_y, abs_z, mag;
  logic               used_r, zero_p_r, zero_r_r;

  assign gp_mul = 33'(gx_r) * 33'($signed({1'b0, gain_r}));
  assign gr_mul = 33'(gy_r) * 33'($signed({1'b0, gain_r}));
  assign abs_x  = ax_r[15] ? 17'(-{ax_r[15], ax_r}) : {1'b0, ax_r};
  assign abs_y  = ay_r[15] ? 17'(-{ay_r[15], ay_r}) : {1'b0, ay_r};
  assign abs_z  = az_r[15] ? 17'(-{az_r[15], az_r}) : {1'b0, az_r};
  // at most 98304, fits 17 bits
  assign mag    = abs_x + abs_y + abs_z;

  always_ff @(posedge clk) begin
    if (state_r == S_MUL) begin
      gp_mul_r <= gp_mul;
      gr_mul_r <= gr_mul;
      used_r   <= (mag > mag_lo_r) && (mag < mag_hi_r);
      zero_p_r <= (ay_r == '0) && (az_r == '0);
      zero_r_r <= (ax_r == '0) && (az_r == '0);
    end
  end

  // saturate a grown gyro sum to 32 bits
  function automatic logic signed [31:0] sat_gyro(input logic signed [33:0] v);
    if (v[33:31] == 3'b000 || v[33:31] == 3'b111) return v[31:0];
    return v[33] ? 32'sh8000_0000 : 32'sh7fff_ffff;
  endfunction

  // saturate a shifted blend sum to 32 bits
  function automatic logic signed [31:0] sat_blend(input logic signed [BW-17:0] v);
    if (v[BW-17:31] == '0 || v[BW-17:31] == '1) return v[31:0];
    return v[BW-17] ? 32'sh8000_0000 : 32'sh7fff_ffff;
  endfunction

  // pitch atan2(ay, az) enters in S_MUL, roll atan2(ax, az) right behind it
  ictf_ctl_t          ch_in_ctl, ch_out_ctl;
  logic signed [15:0] ch_y;
  logic signed [ZW-1:0] ch_z;

  assign ch_in_ctl.vld = (state_r == S_MUL) || (state_r == S_ADD);
  assign ch_in_ctl.tag = (state_r == S_ADD) ? TAG_ROLL : TAG_PITCH;
  assign ch_y          = (state_r == S_ADD) ? ax_r : ay_r;

  ictf_cordic_chain #(
    .CORDIC_STEPS    (CORDIC_STEPS),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
    .ZW              (ZW)
  ) u_chain (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl_i (ch_in_ctl),
    .y_i   (ch_y),
    .x_i   (az_r),
    .ctl_o (ch_out_ctl),
    .z_o   (ch_z)
  );

  // accel angles as they leave the chain; both operands zero gives angle zero
  logic signed [ZW-1:0] acc_p_r, acc_r_r;

  always_ff @(posedge clk) begin
    if (ch_out_ctl.vld) begin
      if (ch_out_ctl.tag == TAG_PITCH) begin
        acc_p_r <= zero_p_r ? '0 : ch_z;
      end else begin
        acc_r_r <= zero_r_r ? '0 : ch_z;
      end
    end
  end

  // blend products: one multiplier per term, summed next cycle
  logic        [16:0]   w_comp;
  logic signed [BW-1:0] bp_a_r, bp_b_r, br_a_r, br_b_r;
  logic signed [BW-1:0] bp_sum, br_sum;
  logic signed [BW-17:0] bp_sh, br_sh;

  assign w_comp = 17'(18'h10000 - {2'b00, weight_r});

  // angle state
  logic signed [31:0] pitch_r, roll_r;

  always_ff @(posedge clk) begin
    if (state_r == S_BMUL) begin
      bp_a_r <= BW'(pitch_r) * BW'($signed({1'b0, weight_r}));
      bp_b_r <= BW'(acc_p_r) * BW'($signed({1'b0, w_comp}));
      br_a_r <= BW'(roll_r) * BW'($signed({1'b0, weight_r}));
      br_b_r <= BW'(acc_r_r) * BW'($signed({1'b0, w_comp}));
    end
  end

  assign bp_sum = bp_a_r + bp_b_r + HALF;
  assign br_sum = br_a_r + br_b_r + HALF;
  // arithmetic shift by 16, floor rounding
  assign bp_sh  = bp_sum[BW-1:16];
  assign br_sh  = br_sum[BW-1:16];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pitch_r <= '0;
      roll_r  <= '0;
    end else if (state_r == S_ADD) begin
      pitch_r <= sat_gyro(34'(pitch_r) + 34'(gp_mul_r));
      roll_r  <= sat_gyro(34'(roll_r) - 34'(gr_mul_r));
    end else if (state_r == S_BSUM) begin
      pitch_r <= sat_blend(bp_sh);
      roll_r  <= sat_blend(br_sh);
    end
  end

  // output register: lets the result wait while the next item comes in
  logic        out_valid_r, out_valid_nxt, out_load;
  logic [31:0] out_pitch_r, out_roll_r;
  logic        out_used_r;

  assign out_load      = (state_r == S_DONE) && (!out_valid_r || out_tready);
  assign out_valid_nxt = out_load || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pitch_r <= pitch_r;
      out_roll_r  <= roll_r;
      out_used_r  <= used_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_roll_r, out_pitch_r};
  assign out_tuser  = out_used_r;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc) state_nxt = S_MUL;
      S_MUL:   state_nxt = S_ADD;
      S_ADD:   state_nxt = S_WAIT;
      // roll angle is the second one out of the chain
      S_WAIT:  if (ch_out_ctl.vld && ch_out_ctl.tag == TAG_ROLL) begin
        state_nxt = used_r ? S_BMUL : S_DONE;
      end
      S_BMUL:  state_nxt = S_BSUM;
      S_BSUM:  state_nxt = S_DONE;
      S_DONE:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // chain results only ever show up while the sequencer waits for them
  a_chain_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    ch_out_ctl.vld |-> (state_r == S_WAIT))
    else $error("cordic result outside wait state");

  // an accepted item starts the gyro step next cycle
  a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_MUL))
    else $error("accepted item did not start");

  // blending only happens inside the magnitude window
  a_blend_used: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BMUL) |-> used_r)
    else $error("blend without accel correction");

endmodule

`default_nettype wire

// ----- sim/tb_imu_complementary_tilt_filter_core.sv -----
`timescale 1ns / 1ps

module tb_imu_complementary_tilt_filter_core;
  import ictf_pkg::*;

  // block runs at its default parameters
  localparam int STEPS   = 16;
  localparam int FRAC    = 16;
  localparam int LATENCY = STEPS + 6;

  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;

  // one imu sample, packed exactly as in_tdata (gyro x in the lowest bits)
  typedef struct packed {
    logic signed [15:0] az;
    logic signed [15:0] ay;
    logic signed [15:0] ax;
    logic signed [15:0] gy;
    logic signed [15:0] gx;
  } imu_sample_t;

  // one result, packed as {out_tuser, out_tdata}
  typedef struct packed {
    logic               used;
    logic signed [31:0] roll;
    logic signed [31:0] pitch;
  } tilt_t;

  // a step of the directed plan: either a register write or a sample
  typedef struct {
    bit          is_cfg;
    logic [3:0]  idx;
    logic [16:0] val;
    imu_sample_t smp;
    bit          known;
    tilt_t       want;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [79:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_index = '0;
  logic [16:0] cfg_data = '0;

  bit          no_gaps = 1'b0;
  int unsigned mismatches = 0;

  // expected results, oldest first
  tilt_t tilt_expected_q[$];

  // mirror of the block: registers at reset defaults, angles at zero
  logic [15:0]        gain_r = 16'd10;
  logic [15:0]        weight_r = 16'd64225;
  logic [16:0]        mag_lo_r = 17'd8192;
  logic [16:0]        mag_hi_r = 17'd32768;
  logic signed [31:0] pitch_r = '0;
  logic signed [31:0] roll_r = '0;

  // atan(2^-i) in degrees with 24 fraction bits
  longint atan_deg_tbl [0:15] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367,
    234684, 117342, 58671, 29335
  };

  imu_complementary_tilt_filter_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // tilt predictor
  // ---------------------------------------------------------------------------

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > S32_MAX) return S32_MAX[31:0];
    if (v < S32_MIN) return S32_MIN[31:0];
    return v[31:0];
  endfunction

  function automatic longint abs16(input logic signed [15:0] v);
    return (v < 0) ? -longint'(v) : longint'(v);
  endfunction

  // vectoring cordic, degrees in the angle format; left half plane folded by 180
  function automatic longint tilt_atan2(input longint y, input longint x);
    longint xs, ys, z, dx, dy, ang;
    xs = x;
    ys = y;
    z  = 0;
    if (xs == 0 && ys == 0) return 0;
    if (xs < 0) begin
      z  = (ys >= 0) ? (longint'(180) <<< FRAC) : -(longint'(180) <<< FRAC);
      xs = -xs;
      ys = -ys;
    end
    xs = xs * 16384;
    ys = ys * 16384;
    for (int i = 0; i < STEPS; i++) begin
      dx  = ys >>> i;
      dy  = xs >>> i;
      // table entry rounded half up to the angle fraction width
      ang = (atan_deg_tbl[i] + (longint'(1) <<< (23 - FRAC))) >>> (24 - FRAC);
      if (ys > 0) begin
        xs = xs + dx;
        ys = ys - dy;
        z  = z + ang;
      end else begin
        xs = xs - dx;
        ys = ys + dy;
        z  = z - ang;
      end
    end
    return z;
  endfunction

  function automatic logic signed [31:0] blend_angle(input logic signed [31:0] a,
                                                     input longint acc);
    longint w, sum;
    w   = longint'(weight_r);
    sum = longint'(a) * w + acc * (65536 - w) + 32768;
    return clamp32(sum >>> 16);
  endfunction

  task automatic advance_tilt(input imu_sample_t s, output tilt_t r);
    longint mag;
    bit     hit;
    pitch_r = clamp32(longint'(pitch_r) + longint'(s.gx) * longint'(gain_r));
    roll_r  = clamp32(longint'(roll_r) - longint'(s.gy) * longint'(gain_r));
    mag = abs16(s.ax) + abs16(s.ay) + abs16(s.az);
    hit = (mag > longint'(mag_lo_r)) && (mag < longint'(mag_hi_r));
    if (hit) begin
      pitch_r = blend_angle(pitch_r, tilt_atan2(s.ay, s.az));
      roll_r  = blend_angle(roll_r, tilt_atan2(s.ax, s.az));
    end
    r.pitch = pitch_r;
    r.roll  = roll_r;
    r.used  = hit;
  endtask

  task automatic note_reg(input logic [3:0] idx, input logic [16:0] val);
    case (idx)
      CFG_GYRO_GAIN:      gain_r   = val[15:0];
      CFG_BLEND_WEIGHT:   weight_r = val[15:0];
      CFG_MAGNITUDE_LOW:  mag_lo_r = val;
      CFG_MAGNITUDE_HIGH: mag_hi_r = val;
      default: ;  // unknown index, block ignores it
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic imu_sample_t mk(input int gx, input int gy, input int ax,
                                     input int ay, input int az);
    imu_sample_t s;
    s.gx = gx[15:0];
    s.gy = gy[15:0];
    s.ax = ax[15:0];
    s.ay = ay[15:0];
    s.az = az[15:0];
    return s;
  endfunction

  function automatic int spread(input int amp);
    return int'($urandom_range(0, 2 * amp)) - amp;
  endfunction

  function automatic plan_row_t item_row(input int gx, input int gy, input int ax,
                                         input int ay, input int az);
    plan_row_t r;
    r.is_cfg = 1'b0;
    r.idx    = '0;
    r.val    = '0;
    r.smp    = mk(gx, gy, ax, ay, az);
    r.known  = 1'b0;
    r.want   = '0;
    return r;
  endfunction

  // sample whose result is plain to see: typed in rather than predicted
  function automatic plan_row_t known_row(input int gx, input int gy, input int ax,
                                          input int ay, input int az, input int p,
                                          input int q, input bit u);
    plan_row_t r;
    r            = item_row(gx, gy, ax, ay, az);
    r.known      = 1'b1;
    r.want.pitch = p;
    r.want.roll  = q;
    r.want.used  = u;
    return r;
  endfunction

  function automatic plan_row_t cfg_row(input logic [3:0] idx, input logic [16:0] val);
    plan_row_t r;
    r        = item_row(0, 0, 0, 0, 0);
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.val    = val;
    return r;
  endfunction

  // present one sample with random gaps, predict once the handshake completes
  task automatic send_sample(input imu_sample_t s, input bit known, input tilt_t want);
    tilt_t pred;
    while (!no_gaps && $urandom_range(0, 99) < 16) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    advance_tilt(s, pred);
    tilt_expected_q.push_back(known ? want : pred);
  endtask

  // every sample yields a result, so an empty queue means the block is idle
  task automatic wait_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (tilt_expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [3:0] idx, input logic [16:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    note_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // result side: random backpressure and checking
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    out_tready <= no_gaps || ($urandom_range(0, 99) >= 16);
  end

  always @(posedge clk) begin : check_results
    tilt_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser[0], out_tdata};
      if (tilt_expected_q.size() == 0) begin
        $error("result item with no expected result pending: pitch %0d roll %0d",
               got.pitch, got.roll);
        mismatches++;
      end else begin
        want = tilt_expected_q.pop_front();
        if (got.pitch !== want.pitch) begin
          $error("pitch_out: expected %0d, got %0d", want.pitch, got.pitch);
          mismatches++;
        end
        if (got.roll !== want.roll) begin
          $error("roll_out: expected %0d, got %0d", want.roll, got.roll);
          mismatches++;
        end
        if (got.used !== want.used) begin
          $error("accel_used: expected %0d, got %0d", want.used, got.used);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    plan_row_t   plan[$];
    imu_sample_t s;
    int          kind;

    // defaults: gain 10, weight 64225, window (8192, 32768)
    plan.push_back(known_row(0, 0, 0, 0, 0, 0, 0, 1'b0));
    plan.push_back(known_row(32767, -32768, 0, 0, 0, 327670, 327680, 1'b0));
    plan.push_back(known_row(-32768, 32767, 0, 0, 0, -10, 10, 1'b0));
    // both atan2 operands zero for pitch, straight up for roll
    plan.push_back(item_row(0, 0, 16384, 0, 0));
    // z zero with y negative
    plan.push_back(item_row(0, 0, -16384, 0, 0));
    // negative z folds by +180 or -180 depending on the sign of y
    plan.push_back(item_row(0, 0, 100, 200, -16000));
    plan.push_back(item_row(0, 0, -100, -200, -16000));
    plan.push_back(item_row(0, 0, 0, 0, -16000));
    // window edges: both limits are exclusive
    plan.push_back(item_row(0, 0, 4096, 4096, 0));
    plan.push_back(item_row(0, 0, 0, 0, 8193));
    plan.push_back(item_row(0, 0, -10922, -10922, -10923));
    plan.push_back(item_row(0, 0, 1, 0, 32767));
    // extreme registers; bit 16 of a 16-bit register is dropped
    plan.push_back(cfg_row(CFG_GYRO_GAIN, 17'h1FFFF));
    plan.push_back(cfg_row(CFG_BLEND_WEIGHT, 17'h00000));
    plan.push_back(cfg_row(CFG_MAGNITUDE_LOW, 17'h00000));
    plan.push_back(cfg_row(CFG_MAGNITUDE_HIGH, 17'h1FFFF));
    // gyro steps drive both angles into saturation and back
    plan.push_back(item_row(32767, -32768, 0, 0, 0));
    plan.push_back(known_row(32767, -32768, 0, 0, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0));
    plan.push_back(known_row(-32768, 32767, 0, 0, 0, 32767, 98302, 1'b0));
    plan.push_back(item_row(-32768, 32767, 0, 0, 0));
    plan.push_back(known_row(-32768, 32767, 0, 0, 0, 32'sh8000_0000, 32'sh8000_0000, 1'b0));
    // zero weight: angles become the accel angles alone
    plan.push_back(item_row(0, 0, -32768, -32768, -32768));
    plan.push_back(item_row(-1, 1, 32767, 32767, 32767));
    // indexes past the register list are ignored
    plan.push_back(cfg_row(4'd4, 17'h1FFFF));
    plan.push_back(cfg_row(4'd15, 17'h1FFFF));
    // crossed limits never correct
    plan.push_back(cfg_row(CFG_MAGNITUDE_LOW, 17'd50000));
    plan.push_back(cfg_row(CFG_MAGNITUDE_HIGH, 17'd1000));
    plan.push_back(item_row(5, -7, 10000, 10000, 10000));
    // zero gain, the largest weight (65535) on the integrated angle
    plan.push_back(cfg_row(CFG_GYRO_GAIN, 17'd0));
    plan.push_back(cfg_row(CFG_BLEND_WEIGHT, 17'hFFFF));
    plan.push_back(cfg_row(CFG_MAGNITUDE_LOW, 17'd0));
    plan.push_back(cfg_row(CFG_MAGNITUDE_HIGH, 17'h1FFFF));
    plan.push_back(item_row(12345, -321, -20000, 3000, 15000));
    plan.push_back(item_row(0, 0, 20000, -3000, 15000));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        wait_results();
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        send_sample(plan[i].smp, plan[i].known, plan[i].want);
      end
    end

    // random phases, each with its own register setting
    for (int ph = 0; ph < 5; ph++) begin
      wait_results();
      case (ph)
        0: begin
          write_reg(CFG_GYRO_GAIN, {1'($urandom_range(0, 1)), 16'($urandom_range(0, 64))});
          write_reg(CFG_BLEND_WEIGHT, 17'($urandom_range(60000, 65535)));
          write_reg(CFG_MAGNITUDE_LOW, 17'($urandom_range(0, 12000)));
          write_reg(CFG_MAGNITUDE_HIGH, 17'($urandom_range(20000, 131071)));
        end
        1: begin
          // anything goes, limits may cross
          write_reg(CFG_GYRO_GAIN, 17'($urandom));
          write_reg(CFG_BLEND_WEIGHT, 17'($urandom));
          write_reg(CFG_MAGNITUDE_LOW, 17'($urandom));
          write_reg(CFG_MAGNITUDE_HIGH, 17'($urandom));
        end
        2: begin
          write_reg(CFG_GYRO_GAIN, 17'd0);
          write_reg(CFG_BLEND_WEIGHT, 17'hFFFF);
          write_reg(CFG_MAGNITUDE_LOW, 17'd0);
          write_reg(CFG_MAGNITUDE_HIGH, 17'h1FFFF);
        end
        3: begin
          write_reg(CFG_GYRO_GAIN, 17'($urandom_range(1, 300)));
          write_reg(CFG_BLEND_WEIGHT, 17'd0);
          write_reg(CFG_MAGNITUDE_LOW, 17'd0);
          write_reg(CFG_MAGNITUDE_HIGH, 17'h1FFFF);
        end
        default: begin
          write_reg(CFG_GYRO_GAIN, 17'($urandom_range(0, 2000)));
          write_reg(CFG_BLEND_WEIGHT, {1'($urandom_range(0, 1)), 16'($urandom)});
          write_reg(CFG_MAGNITUDE_LOW, 17'd8192);
          write_reg(CFG_MAGNITUDE_HIGH, 17'd32768);
        end
      endcase
      // one whole phase runs back to back on both sides
      no_gaps <= (ph == 2);
      repeat (150) begin
        kind = $urandom_range(0, 99);
        if (kind < 75) begin
          // plausible motion: modest rates, each accel axis within +-16000
          s = mk(spread(3000), spread(3000), spread(16000), spread(16000), spread(16000));
        end else begin
          s = mk($urandom, $urandom, $urandom, $urandom, $urandom);
        end
        send_sample(s, 1'b0, '0);
      end
    end

    wait_results();
    no_gaps <= 1'b0;
    // catch any stray result after the last expected one
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_imu_complementary_tilt_filter_core: PASS");
    end else begin
      $display("tb_imu_complementary_tilt_filter_core: FAIL");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("tb_imu_complementary_tilt_filter_core: FAIL");
    $finish;
  end

endmodule
